// File: rtl/mats_pkg.sv
package mats_pkg;

    localparam int unsigned PORT_COUNT_MAX_DEF = 4;
    localparam int unsigned REQUESTERS_DEF     = 8;
    localparam int unsigned SPM_BYTES_DEF      = 65536;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned DIV_W      = 17;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_READ      = 2'd0,
        CMD_WRITE     = 2'd1,
        CMD_DMA_LOAD  = 2'd2,
        CMD_DMA_STORE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_NOT_INIT = 2'd1,
        ERR_BOUNDS   = 2'd2
    } err_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCESS_LATENCY = 3'd0,
        REG_DMA_BANDWIDTH  = 3'd1,
        REG_DMA_STARTUP    = 3'd2,
        REG_SHARED_MODE    = 3'd3,
        REG_PORTS_IN_USE   = 3'd4,
        REG_SPAD_BYTES     = 3'd5,
        REG_SPM_READY      = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_UPDATE,
        ST_OUT
    } exec_state_t;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        cmd_t        cmd;
        logic [5:0]  requester;
        logic [16:0] size;
        logic [47:0] now;
        err_t        err;
    } req_t;

endpackage

// File: rtl/mats_front.sv
module mats_front #(
    parameter int unsigned REQUESTERS = mats_pkg::REQUESTERS_DEF,
    parameter int unsigned SPM_BYTES  = mats_pkg::SPM_BYTES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_cmd,
    input  logic [2:0]      in_requester,
    input  logic [15:0]     in_offset,
    input  logic [16:0]     in_size,
    input  logic [47:0]     in_now,
    input  logic [16:0]     spad_bytes,
    input  logic            spm_ready,
    output logic            q_valid,
    input  logic            q_ready,
    output mats_pkg::req_t  q_data
);

    localparam int unsigned QD = 2;

    mats_pkg::req_t q_mem [QD];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    mats_pkg::req_t cls;
    logic [17:0] bound, endp;
    logic [5:0] rq;

    always_comb begin
        bound = ({1'b0, spad_bytes} < 18'(SPM_BYTES)) ? {1'b0, spad_bytes} : 18'(SPM_BYTES);
        endp  = 18'(in_offset) + 18'(in_size);
        rq    = 6'(32'(in_requester) % REQUESTERS);
        cls.cmd       = mats_pkg::cmd_t'(in_cmd);
        cls.requester = rq;
        cls.size      = in_size;
        cls.now       = in_now;
        if (!spm_ready) begin
            cls.err = mats_pkg::ERR_NOT_INIT;
        end else if (endp > bound) begin
            cls.err = mats_pkg::ERR_BOUNDS;
        end else begin
            cls.err = mats_pkg::ERR_OK;
        end
    end

    assign in_ready = (cnt_reg != 2'(QD));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = q_mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            q_mem[wp_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (in_valid && in_ready) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_valid && q_ready) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'(QD))
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !q_valid)
        else $error("queue valid while empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !q_ready) |=> q_valid)
        else $error("queue lost entry");

endmodule

// File: rtl/mats_back.sv
module mats_back #(
    parameter int unsigned PORT_COUNT_MAX = mats_pkg::PORT_COUNT_MAX_DEF,
    parameter int unsigned REQUESTERS     = mats_pkg::REQUESTERS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  mats_pkg::req_t  q_data,
    input  logic [15:0]     access_latency,
    input  logic [12:0]     dma_bandwidth,
    input  logic [15:0]     dma_startup,
    input  logic            shared_mode,
    input  logic [2:0]      ports_in_use,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [359:0]    out_data
);

    localparam int unsigned PW = (PORT_COUNT_MAX > 1) ? $clog2(PORT_COUNT_MAX) : 1;
    localparam int unsigned RW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;

    mats_pkg::exec_state_t state_reg, state_next;
    mats_pkg::req_t req_reg;
    logic [47:0] pfree_reg [PORT_COUNT_MAX];
    logic [31:0] rd_reg [REQUESTERS];
    logic [31:0] wr_reg [REQUESTERS];
    logic [31:0] ld_reg [REQUESTERS];
    logic [31:0] sd_reg [REQUESTERS];
    logic [47:0] bl_reg [REQUESTERS];
    logic [47:0] bs_reg [REQUESTERS];
    logic [31:0] sc_reg [REQUESTERS];

    // Restoring divider for ceil(size / bandwidth), one quotient bit a cycle.
    logic [16:0] rem_reg, quo_reg, dvd_reg;
    logic [4:0]  dcnt_reg;
    logic [12:0] bw;
    logic [17:0] trial;

    logic [4:0]    pidx_reg;
    logic [PW-1:0] best_reg;
    logic [47:0]   earliest_reg;
    logic [4:0]    nports;

    logic [47:0] base_reg, stall_reg;
    logic [359:0] obuf_reg;
    logic         ovalid_reg;
    logic         out_free;

    logic [RW-1:0] ri;
    logic [47:0] start, stall_c, base_c, lat_c, pnew;
    logic [31:0] rd_n, wr_n, ld_n, sd_n, sc_n;
    logic [47:0] bl_n, bs_n;
    logic        ok;

    assign ri = req_reg.requester[RW-1:0];
    assign bw = (dma_bandwidth == 13'd0) ? 13'd1 : dma_bandwidth;
    assign trial = {rem_reg, dvd_reg[16]} - 18'(bw);
    assign nports = (ports_in_use == 3'd0) ? 5'd1 :
                    (32'(ports_in_use) > PORT_COUNT_MAX) ? 5'(PORT_COUNT_MAX) :
                    5'(ports_in_use);
    assign ok = (req_reg.err == mats_pkg::ERR_OK);
    // The output register can take a new result when it is empty or being emptied.
    assign out_free = !ovalid_reg || out_ready;

    function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? mats_pkg::MAX48 : s[47:0];
    endfunction

    function automatic logic [31:0] inc32(input logic [31:0] a);
        return (a == mats_pkg::MAX32) ? a : a + 32'd1;
    endfunction

    always_comb begin
        if (req_reg.cmd == mats_pkg::CMD_READ || req_reg.cmd == mats_pkg::CMD_WRITE) begin
            base_c = 48'(access_latency);
        end else begin
            base_c = 48'(dma_startup) + 48'(quo_reg) + 48'(rem_reg != 17'd0);
        end
        start   = (req_reg.now > earliest_reg) ? req_reg.now : earliest_reg;
        stall_c = shared_mode ? start - req_reg.now : 48'd0;
        pnew    = sat48(start, base_reg);
        lat_c   = sat48(base_reg, stall_reg);
        rd_n = rd_reg[ri]; wr_n = wr_reg[ri]; ld_n = ld_reg[ri]; sd_n = sd_reg[ri];
        bl_n = bl_reg[ri]; bs_n = bs_reg[ri]; sc_n = sc_reg[ri];
        if (ok) begin
            if (shared_mode && stall_reg != 48'd0) begin
                sc_n = inc32(sc_n);
            end
            case (req_reg.cmd)
                mats_pkg::CMD_READ:     rd_n = inc32(rd_n);
                mats_pkg::CMD_WRITE:    wr_n = inc32(wr_n);
                mats_pkg::CMD_DMA_LOAD: begin
                    ld_n = inc32(ld_n);
                    bl_n = sat48(bl_n, 48'(req_reg.size));
                end
                default: begin
                    sd_n = inc32(sd_n);
                    bs_n = sat48(bs_n, 48'(req_reg.size));
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mats_pkg::ST_IDLE:   if (q_valid) state_next = mats_pkg::ST_DIV;
            mats_pkg::ST_DIV:    if (dcnt_reg == 5'd0) state_next = mats_pkg::ST_SEARCH;
            mats_pkg::ST_SEARCH: if (pidx_reg >= nports) state_next = mats_pkg::ST_UPDATE;
            mats_pkg::ST_UPDATE: if (out_free) state_next = mats_pkg::ST_OUT;
            mats_pkg::ST_OUT:    state_next = mats_pkg::ST_IDLE;
            default:             state_next = mats_pkg::ST_IDLE;
        endcase
    end

    assign q_ready   = (state_reg == mats_pkg::ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mats_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < PORT_COUNT_MAX; i++) pfree_reg[i] <= '0;
            for (int i = 0; i < REQUESTERS; i++) begin
                rd_reg[i] <= '0; wr_reg[i] <= '0; ld_reg[i] <= '0; sd_reg[i] <= '0;
                bl_reg[i] <= '0; bs_reg[i] <= '0; sc_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == mats_pkg::ST_UPDATE && out_free) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == mats_pkg::ST_UPDATE && out_free) begin
                if (ok && shared_mode) begin
                    pfree_reg[best_reg] <= pnew;
                end
                rd_reg[ri] <= rd_n; wr_reg[ri] <= wr_n; ld_reg[ri] <= ld_n;
                sd_reg[ri] <= sd_n; bl_reg[ri] <= bl_n; bs_reg[ri] <= bs_n;
                sc_reg[ri] <= sc_n;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            mats_pkg::ST_IDLE: begin
                req_reg  <= q_data;
                dvd_reg  <= q_data.size;
                rem_reg  <= '0;
                quo_reg  <= '0;
                dcnt_reg <= 5'(mats_pkg::DIV_W);
            end
            mats_pkg::ST_DIV: begin
                if (dcnt_reg != 5'd0) begin
                    dvd_reg <= {dvd_reg[15:0], 1'b0};
                    if (!trial[17]) begin
                        rem_reg <= trial[16:0];
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[15:0], dvd_reg[16]};
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 5'd1;
                end else begin
                    base_reg     <= base_c;
                    earliest_reg <= pfree_reg[0];
                    best_reg     <= '0;
                    pidx_reg     <= 5'd1;
                end
            end
            mats_pkg::ST_SEARCH: begin
                if (pidx_reg < nports) begin
                    if (pfree_reg[pidx_reg[PW-1:0]] < earliest_reg) begin
                        earliest_reg <= pfree_reg[pidx_reg[PW-1:0]];
                        best_reg     <= pidx_reg[PW-1:0];
                    end
                    pidx_reg <= pidx_reg + 5'd1;
                end else begin
                    stall_reg <= ok ? stall_c : 48'd0;
                end
            end
            mats_pkg::ST_UPDATE: begin
                if (out_free) begin
                    obuf_reg <= {6'd0, sc_n, bs_n, bl_n, sd_n, ld_n, wr_n, rd_n,
                                 req_reg.err, stall_reg, ok ? lat_c : 48'd0};
                end
            end
            default: begin
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != mats_pkg::ST_IDLE) |-> !q_ready)
        else $error("accepted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mats_pkg::ST_UPDATE && out_free) |=> (state_reg == mats_pkg::ST_OUT))
        else $error("update not followed by output");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && !out_ready) |=> (ovalid_reg && $stable(obuf_reg)))
        else $error("result changed while waiting");

endmodule

// File: rtl/multiport_access_timing_scheduler_top.sv
// A request waits in the queue, then the back part runs the restoring divider for the DMA
// ceiling, searches ports_in_use ports (clamped to 1..PORT_COUNT_MAX) for the earliest free
// one, updates counters and registers the result, which may then wait while it is held.
// The back part takes no new transaction until it has registered its result; a two-entry queue
// decouples acceptance from execution. Reset (aresetn low, synchronous) restores
// register defaults and clears port free times, counters, the queue and the output.
module multiport_access_timing_scheduler_top #(
    parameter int unsigned PORT_COUNT_MAX = mats_pkg::PORT_COUNT_MAX_DEF,
    parameter int unsigned REQUESTERS     = mats_pkg::REQUESTERS_DEF,
    parameter int unsigned SPM_BYTES      = mats_pkg::SPM_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[1:0], requester[4:2], offset[20:5], size[37:21], now[85:38], zero fill
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // latency[47:0], stall_res[95:48], error[97:96], reads[129:98],
    // writes[161:130], dma_loads[193:162], dma_stores[225:194],
    // loaded_bytes[273:226], stored_bytes[321:274], stalls[353:322], zero fill
    output logic [359:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [mats_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [15:0] acc_lat_reg;
    logic [12:0] dma_bw_reg;
    logic [15:0] dma_st_reg;
    logic        shared_reg;
    logic [2:0]  ports_reg;
    logic [16:0] spad_bytes_reg;
    logic        spm_ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_lat_reg    <= 16'd1;
            dma_bw_reg     <= 13'd8;
            dma_st_reg     <= '0;
            shared_reg     <= 1'b0;
            ports_reg      <= 3'd1;
            spad_bytes_reg <= '0;
            spm_ready_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (mats_pkg::reg_idx_t'(cfg_index))
                mats_pkg::REG_ACCESS_LATENCY: acc_lat_reg    <= cfg_data[15:0];
                mats_pkg::REG_DMA_BANDWIDTH:  dma_bw_reg     <= cfg_data[12:0];
                mats_pkg::REG_DMA_STARTUP:    dma_st_reg     <= cfg_data[15:0];
                mats_pkg::REG_SHARED_MODE:    shared_reg     <= cfg_data[0];
                mats_pkg::REG_PORTS_IN_USE:   ports_reg      <= cfg_data[2:0];
                mats_pkg::REG_SPAD_BYTES:     spad_bytes_reg <= cfg_data[16:0];
                mats_pkg::REG_SPM_READY:      spm_ready_reg  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    logic           q_valid, q_ready;
    mats_pkg::req_t q_data;

    mats_front #(.REQUESTERS(REQUESTERS), .SPM_BYTES(SPM_BYTES)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[1:0]), .in_requester(s_tdata[4:2]),
        .in_offset(s_tdata[20:5]), .in_size(s_tdata[37:21]), .in_now(s_tdata[85:38]),
        .spad_bytes(spad_bytes_reg), .spm_ready(spm_ready_reg),
        .q_valid, .q_ready, .q_data
    );

    mats_back #(.PORT_COUNT_MAX(PORT_COUNT_MAX), .REQUESTERS(REQUESTERS)) u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_data,
        .access_latency(acc_lat_reg), .dma_bandwidth(dma_bw_reg),
        .dma_startup(dma_st_reg), .shared_mode(shared_reg), .ports_in_use(ports_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

endmodule
